// ----- rtl/key_table_block_parser_defines.svh -----
// Assertion macros shared by the key-table block parser RTL.
`ifndef KEY_TABLE_BLOCK_PARSER_DEFINES_SVH
`define KEY_TABLE_BLOCK_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define KTBP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key table parser: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and held off during reset.
`define KTBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key table parser: next-cycle check failed");

`endif

// ----- rtl/ktbp_pkg.sv -----
// Types, constants and result builders for the key-table block parser.
package ktbp_pkg;

    // Sizing of the block.
    localparam int MAX_KEYS          = 96;
    localparam int MAX_FORMULA_BYTES = 256;
    localparam int FLEN_W            = $clog2(MAX_FORMULA_BYTES + 3);
    localparam int Q_DEPTH           = 4;
    localparam int Q_PTR_W           = $clog2(Q_DEPTH);
    localparam int Q_CNT_W           = $clog2(Q_DEPTH + 1);

    // Result kinds.
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Value types reported on a key entry.
    localparam logic [2:0] VT_CHAR    = 3'd0;
    localparam logic [2:0] VT_UNKNOWN = 3'd4;
    localparam logic [2:0] VT_FORMULA = 3'd5;

    // Byte codes of the block.
    localparam logic [7:0] B_PLAIN    = 8'h00;
    localparam logic [7:0] B_LITERAL  = 8'h01;
    localparam logic [7:0] B_STATE    = 8'h02;
    localparam logic [7:0] B_WIDE     = 8'h79;
    localparam logic [7:0] B_OP_END_A = 8'h59;
    localparam logic [7:0] B_OP_END_B = 8'h66;
    localparam logic [7:0] KEY_LOW    = 8'h20;
    localparam logic [7:0] KEY_HIGH   = 8'h7e;

    // Plain value type codes (upper five bits of the first value byte).
    localparam logic [4:0] PT_CHAR    = 5'd0;
    localparam logic [4:0] PT_INITIAL = 5'd2;
    localparam logic [4:0] PT_MEDIAL  = 5'd3;
    localparam logic [4:0] PT_FINAL   = 5'd4;
    localparam logic [4:0] PT_WIDE    = 5'd10;

    localparam logic [11:0] SLOT_NONE = 12'hfff;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [6:0]         key_char;
        logic [2:0]         value_type;
        logic [10:0]        code_index;
        logic signed [11:0] formula_initial;
        logic signed [11:0] formula_medial;
        logic signed [11:0] formula_final;
        logic [6:0]         key_total;
        logic               last;
    } t_result;

    // Key entry beat.
    function automatic t_result mk_key(logic [6:0] kc, logic [2:0] vt, logic [10:0] idx,
                                       logic [11:0] fi, logic [11:0] fm, logic [11:0] ff);
        t_result r;
        r.kind            = KIND_KEY;
        r.key_char        = kc;
        r.value_type      = vt;
        r.code_index      = idx;
        r.formula_initial = fi;
        r.formula_medial  = fm;
        r.formula_final   = ff;
        r.key_total       = 7'd0;
        r.last            = 1'b0;
        return r;
    endfunction

    // Final status beat.
    function automatic t_result mk_status(logic [1:0] kind, logic [6:0] total);
        t_result r;
        r.kind            = kind;
        r.key_char        = 7'd0;
        r.value_type      = VT_CHAR;
        r.code_index      = 11'd0;
        r.formula_initial = SLOT_NONE;
        r.formula_medial  = SLOT_NONE;
        r.formula_final   = SLOT_NONE;
        r.key_total       = (kind == KIND_OK) ? total : 7'd0;
        r.last            = 1'b1;
        return r;
    endfunction

endpackage

// ----- rtl/key_table_block_parser.sv -----
// Key-table block parser: byte-wide header and value parser with a result queue.
//
// Usage: bytes of one key-table block enter on the input channel (i_in_valid,
// o_in_stall, i_in), starting at the eight-byte header, with end_of_stream set
// on the last byte available. Results leave on the output channel (o_out_valid,
// i_out_stall, o_out): one key entry beat per key, then one status beat (ok or
// rejected) with last set, which is lost if it would be a third beat for a byte.
// The beats caused by a byte are written into the result queue when it is
// accepted. Throughput: one byte per cycle while the input does not stall; the
// parse state is updated from each byte by combinational logic and registered,
// and each byte yields at most two beats, which go into a four-entry result
// queue. The input stalls only while the queue has fewer than two free entries.
// When the receiver stalls, the head beat holds and the queue fills; the input
// then stalls after two more beats are waiting.
// Reset empties the queue and returns the parser to the header phase. After a
// status beat, bytes are dropped until one with end_of_stream set; the byte
// after it is taken as a new header.
`include "key_table_block_parser_defines.svh"

module key_table_block_parser
    import ktbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_in     i_in,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out
);

    typedef enum logic [3:0] {
        PH_HEADER, PH_VALUE, PH_PLAIN_A, PH_PLAIN_B, PH_SKIP, PH_FORMULA,
        PH_LIT_A, PH_LIT_B, PH_STATE_ARG, PH_DONE
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [2:0]          r_hdr_cnt, n_hdr_cnt;
    logic [6:0]          r_low, n_low;
    logic [6:0]          r_high, n_high;
    logic [6:0]          r_kpos, n_kpos;
    logic [7:0]          r_fvb, n_fvb;
    logic [1:0]          r_skip, n_skip;
    logic [FLEN_W-1:0]   r_flen, n_flen;
    logic                r_endp, n_endp;
    logic [11:0]         r_sl_i, n_sl_i;
    logic [11:0]         r_sl_m, n_sl_m;
    logic [11:0]         r_sl_f, n_sl_f;
    logic                r_several, n_several;

    t_result             r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;

    logic                in_acc, out_acc;
    logic [1:0]          res_n;
    t_result             res0, res1;

    // Parse logic scratch values.
    logic [7:0]          b;
    logic [4:0]          pt;
    logic [6:0]          total;
    logic [7:0]          span;
    logic [10:0]         v;
    logic                do_vs;
    logic                k1_v, k2_v, st_v;
    t_result             k1, k2;
    logic [1:0]          st_kind;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_in_stall  = r_cnt > Q_CNT_W'(Q_DEPTH - 2);
    assign o_out_valid = r_cnt != '0;
    assign o_out       = r_q[r_rd];

    // Combinational parse of one byte: next state and up to two result beats.
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_low     = r_low;
        n_high    = r_high;
        n_kpos    = r_kpos;
        n_fvb     = r_fvb;
        n_skip    = r_skip;
        n_flen    = r_flen;
        n_endp    = r_endp;
        n_sl_i    = r_sl_i;
        n_sl_m    = r_sl_m;
        n_sl_f    = r_sl_f;
        n_several = r_several;
        b         = i_in.data_byte;
        pt        = '0;
        total     = r_high - r_low + 7'd1;
        span      = '0;
        v         = '0;
        do_vs     = 1'b0;
        k1_v      = 1'b0;
        k2_v      = 1'b0;
        st_v      = 1'b0;
        st_kind   = KIND_REJECT;
        k1        = mk_status(KIND_REJECT, 7'd0);
        k2        = mk_status(KIND_REJECT, 7'd0);
        res0      = k1;
        res1      = k1;
        res_n     = 2'd0;

        if (in_acc) begin
            unique case (r_phase)
                PH_HEADER: begin
                    unique case (r_hdr_cnt)
                        3'd0: st_v = b > 8'd1;
                        3'd1: begin
                            st_v = (b < KEY_LOW) || (b >= KEY_HIGH);
                            n_low = b[6:0];
                        end
                        3'd2: begin
                            span = b - {1'b0, r_low} + 8'd1;
                            st_v = (b <= {1'b0, r_low}) || (b > KEY_HIGH)
                                || (span > 8'(MAX_KEYS));
                            n_high = b[6:0];
                        end
                        3'd3, 3'd4: st_v = b != 8'd0;
                        3'd5:       st_v = b != 8'd1;
                        default:    st_v = 1'b0;
                    endcase
                    if (st_v) begin
                        n_phase = PH_DONE;
                    end else if (r_hdr_cnt == 3'd7) begin
                        n_hdr_cnt = '0;
                        n_kpos    = '0;
                        n_phase   = PH_VALUE;
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                    end
                end
                PH_VALUE: do_vs = 1'b1;
                PH_PLAIN_A: begin
                    pt = b[7:3];
                    if (pt != PT_CHAR && pt != PT_INITIAL && pt != PT_MEDIAL
                        && pt != PT_FINAL && pt != PT_WIDE) begin
                        st_v    = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_fvb   = b;
                        n_phase = PH_PLAIN_B;
                    end
                end
                PH_PLAIN_B: begin
                    pt = r_fvb[7:3];
                    k2_v = 1'b1;
                    k2 = mk_key(r_low + r_kpos,
                                (pt == PT_CHAR) ? VT_CHAR :
                                (pt == PT_WIDE) ? VT_UNKNOWN : 3'(pt - 5'd1),
                                {b, r_fvb[2:0]}, SLOT_NONE, SLOT_NONE, SLOT_NONE);
                    n_kpos = r_kpos + 7'd1;
                    if (pt == PT_WIDE) begin
                        n_skip  = 2'd1;
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 2'd1;
                    if (n_skip == 2'd0) begin
                        n_phase = PH_VALUE;
                    end
                end
                PH_FORMULA: begin
                    n_endp = 1'b0;
                    if (r_endp && (b == B_PLAIN || b == B_LITERAL || b == B_STATE
                                   || b == B_WIDE)) begin
                        // Closing op followed by a value start: the formula is complete.
                        k1_v = 1'b1;
                        if (r_several) begin
                            k1 = mk_key(r_low + r_kpos, VT_FORMULA, 11'd0,
                                        SLOT_NONE, SLOT_NONE, SLOT_NONE);
                        end else begin
                            k1 = mk_key(r_low + r_kpos, VT_FORMULA, 11'd0,
                                        r_sl_i, r_sl_m, r_sl_f);
                        end
                        n_kpos  = r_kpos + 7'd1;
                        n_phase = PH_VALUE;
                        do_vs   = 1'b1;
                    end else if (r_flen >= FLEN_W'(MAX_FORMULA_BYTES)) begin
                        st_v    = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_flen = r_flen + FLEN_W'(1);
                        if (b == B_LITERAL) begin
                            n_phase = PH_LIT_A;
                        end else if (b == B_STATE) begin
                            n_phase = PH_STATE_ARG;
                        end else if (b == B_OP_END_A || b == B_OP_END_B) begin
                            n_endp = 1'b1;
                        end
                    end
                end
                PH_LIT_A: begin
                    n_flen  = r_flen + FLEN_W'(1);
                    n_fvb   = b;
                    n_phase = PH_LIT_B;
                end
                PH_LIT_B: begin
                    // Literal complete: fill its jamo slot, or flag a repeat.
                    n_flen  = r_flen + FLEN_W'(1);
                    n_phase = PH_FORMULA;
                    pt = r_fvb[7:3];
                    v  = {b, r_fvb[2:0]};
                    if (pt == PT_INITIAL) begin
                        if (r_sl_i != SLOT_NONE) n_several = 1'b1;
                        else n_sl_i = {1'b0, v};
                    end else if (pt == PT_MEDIAL) begin
                        if (r_sl_m != SLOT_NONE) n_several = 1'b1;
                        else n_sl_m = {1'b0, v};
                    end else if (pt == PT_FINAL) begin
                        if (r_sl_f != SLOT_NONE) n_several = 1'b1;
                        else n_sl_f = {1'b0, v};
                    end
                end
                PH_STATE_ARG: begin
                    n_flen  = r_flen + FLEN_W'(1);
                    n_phase = PH_FORMULA;
                end
                PH_DONE: begin
                    // Bytes after the status are dropped.
                end
                default: begin
                    st_v    = 1'b1;
                    n_phase = PH_DONE;
                end
            endcase

            // Start of a value, or the terminator after the last key.
            if (do_vs) begin
                if (n_kpos >= total) begin
                    st_v    = 1'b1;
                    st_kind = (b == B_PLAIN) ? KIND_OK : KIND_REJECT;
                    n_phase = PH_DONE;
                end else if (b == B_PLAIN) begin
                    n_phase = PH_PLAIN_A;
                end else if (b == B_WIDE) begin
                    k2_v = 1'b1;
                    k2 = mk_key(r_low + n_kpos, VT_UNKNOWN, 11'd0,
                                SLOT_NONE, SLOT_NONE, SLOT_NONE);
                    n_kpos  = n_kpos + 7'd1;
                    n_skip  = 2'd2;
                    n_phase = PH_SKIP;
                end else if (b == B_LITERAL || b == B_STATE) begin
                    n_sl_i    = SLOT_NONE;
                    n_sl_m    = SLOT_NONE;
                    n_sl_f    = SLOT_NONE;
                    n_several = 1'b0;
                    n_endp    = 1'b0;
                    n_flen    = FLEN_W'(1);
                    n_phase   = (b == B_LITERAL) ? PH_LIT_A : PH_STATE_ARG;
                end else begin
                    st_v    = 1'b1;
                    n_phase = PH_DONE;
                end
            end

            // Early end of the stream, then a full return to the header phase.
            if (i_in.end_of_stream) begin
                if (n_phase != PH_DONE) begin
                    st_v    = 1'b1;
                    st_kind = KIND_REJECT;
                end
                n_phase   = PH_HEADER;
                n_hdr_cnt = '0;
                n_low     = '0;
                n_high    = '0;
                n_kpos    = '0;
                n_fvb     = '0;
                n_skip    = '0;
                n_flen    = '0;
                n_endp    = 1'b0;
                n_sl_i    = SLOT_NONE;
                n_sl_m    = SLOT_NONE;
                n_sl_f    = SLOT_NONE;
                n_several = 1'b0;
            end

            // Order the beats: formula key, other key, status; at most two go out.
            res_n = 2'(k1_v) + 2'(k2_v) + 2'(st_v);
            if (res_n == 2'd3) res_n = 2'd2;
            if (k1_v)      res0 = k1;
            else if (k2_v) res0 = k2;
            else           res0 = mk_status(st_kind, total);
            if (k1_v && k2_v) res1 = k2;
            else              res1 = mk_status(st_kind, total);
        end
    end

    // Parse state, result queue and its pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_low     <= '0;
            r_high    <= '0;
            r_kpos    <= '0;
            r_fvb     <= '0;
            r_skip    <= '0;
            r_flen    <= '0;
            r_endp    <= 1'b0;
            r_sl_i    <= SLOT_NONE;
            r_sl_m    <= SLOT_NONE;
            r_sl_f    <= SLOT_NONE;
            r_several <= 1'b0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_cnt     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_low     <= n_low;
            r_high    <= n_high;
            r_kpos    <= n_kpos;
            r_fvb     <= n_fvb;
            r_skip    <= n_skip;
            r_flen    <= n_flen;
            r_endp    <= n_endp;
            r_sl_i    <= n_sl_i;
            r_sl_m    <= n_sl_m;
            r_sl_f    <= n_sl_f;
            r_several <= n_several;
            if (res_n != 2'd0) begin
                r_q[r_wr] <= res0;
            end
            if (res_n == 2'd2) begin
                r_q[r_wr + Q_PTR_W'(1)] <= res1;
            end
            r_wr  <= r_wr + Q_PTR_W'(res_n);
            r_rd  <= r_rd + Q_PTR_W'(out_acc);
            r_cnt <= r_cnt + Q_CNT_W'(res_n) - Q_CNT_W'(out_acc);
        end
    end

    // Checks on the queue and the parse sequencing.
    `KTBP_ASSERT_NOW(a_queue_bound, 1'b1, r_cnt <= Q_CNT_W'(Q_DEPTH))
    `KTBP_ASSERT_NOW(a_last_is_status, o_out_valid, o_out.last == (o_out.kind != KIND_KEY))
    `KTBP_ASSERT_NOW(a_done_silent, in_acc && r_phase == PH_DONE, res_n == 2'd0)
    `KTBP_ASSERT_NEXT(a_eos_restart, in_acc && i_in.end_of_stream, r_phase == PH_HEADER)

endmodule

// ----- dv/tb_key_table_block_parser.sv -----
// Self-checking testbench for the key-table block parser: random byte streams against a predictor.
module tb_key_table_block_parser;
    import ktbp_pkg::*;

    localparam int ITEMS        = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_LEN     = 120;
    localparam int PAUSE_AT     = 700;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 1000;

    // Parser phases of the predictor.
    typedef enum logic [3:0] {
        ST_HEADER, ST_VALUE, ST_PLAIN_TYPE, ST_PLAIN_INDEX, ST_DISCARD,
        ST_TOKEN, ST_LIT_TYPE, ST_LIT_INDEX, ST_ARG, ST_CLOSED
    } t_phase;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    byte_valid   = 1'b0;
    logic    byte_stall;
    t_in     byte_beat    = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    t_result result_beat;

    t_in        pending_bytes[$];
    t_result    expected_results[$];
    logic [7:0] block_bytes[$];

    int cycle_count  = 0;
    int bytes_sent   = 0;
    int fail_count   = 0;
    int holdoff_left = 0;

    // Predictor state.
    t_phase      st;
    logic [2:0]  hdr_pos;
    logic [6:0]  key_first, key_last, key_next;
    logic [7:0]  held_byte;
    logic [1:0]  discard_left;
    int          token_bytes;
    logic        end_armed;
    logic [11:0] jamo_ini, jamo_med, jamo_fin;
    logic        jamo_clash;
    logic        closed;
    int          beats_now;

    key_table_block_parser i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (byte_valid),
        .o_in_stall  (byte_stall),
        .i_in        (byte_beat),
        .o_out_valid (result_valid),
        .i_out_stall (result_stall),
        .o_out       (result_beat)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_parser();
        st           = ST_HEADER;
        hdr_pos      = '0;
        key_first    = '0;
        key_last     = '0;
        key_next     = '0;
        held_byte    = '0;
        discard_left = '0;
        token_bytes  = 0;
        end_armed    = 1'b0;
        jamo_ini     = SLOT_NONE;
        jamo_med     = SLOT_NONE;
        jamo_fin     = SLOT_NONE;
        jamo_clash   = 1'b0;
        closed       = 1'b0;
    endfunction

    // A single byte yields at most two beats; anything beyond is dropped.
    function automatic void push_result(t_result r);
        if (beats_now < 2) begin
            expected_results.push_back(r);
            beats_now++;
        end
    endfunction

    function automatic void push_key(logic [2:0] vt, logic [10:0] idx,
                                     logic [11:0] fi, logic [11:0] fm, logic [11:0] ff);
        t_result r;
        r                 = '0;
        r.kind            = KIND_KEY;
        r.key_char        = key_first + key_next;
        r.value_type      = vt;
        r.code_index      = idx;
        r.formula_initial = fi;
        r.formula_medial  = fm;
        r.formula_final   = ff;
        push_result(r);
        key_next = key_next + 7'd1;
    endfunction

    function automatic void close_block(logic [1:0] kind);
        t_result r;
        r                 = '0;
        r.kind            = kind;
        r.formula_initial = SLOT_NONE;
        r.formula_medial  = SLOT_NONE;
        r.formula_final   = SLOT_NONE;
        r.key_total       = (kind == KIND_OK) ? key_last - key_first + 7'd1 : 7'd0;
        r.last            = 1'b1;
        push_result(r);
        closed = 1'b1;
        st     = ST_CLOSED;
    endfunction

    // Header: flag byte, key range, fixed marker 00 00 01, two don't-care bytes.
    function automatic void take_header(logic [7:0] b);
        logic bad;
        bad = 1'b0;
        case (hdr_pos)
            3'd0: bad = b > 8'd1;
            3'd1: begin
                bad = b < KEY_LOW || b >= KEY_HIGH;
                if (!bad) key_first = b[6:0];
            end
            3'd2: begin
                bad = b <= {1'b0, key_first} || b > KEY_HIGH ||
                      (int'(b) - int'(key_first) + 1) > MAX_KEYS;
                if (!bad) key_last = b[6:0];
            end
            3'd3, 3'd4: bad = b != 8'd0;
            3'd5: bad = b != 8'd1;
            default: ;
        endcase
        if (bad) begin
            close_block(KIND_REJECT);
        end else if (hdr_pos == 3'd7) begin
            hdr_pos  = '0;
            key_next = '0;
            st       = ST_VALUE;
        end else begin
            hdr_pos = hdr_pos + 3'd1;
        end
    endfunction

    // First byte of a value, or the terminator once every key has a value.
    function automatic void start_value(logic [7:0] b);
        int keys;
        keys = int'(key_last) - int'(key_first) + 1;
        if (int'(key_next) >= keys) begin
            close_block(b == B_PLAIN ? KIND_OK : KIND_REJECT);
        end else if (b == B_PLAIN) begin
            st = ST_PLAIN_TYPE;
        end else if (b == B_WIDE) begin
            push_key(VT_UNKNOWN, '0, SLOT_NONE, SLOT_NONE, SLOT_NONE);
            discard_left = 2'd2;
            st           = ST_DISCARD;
        end else if (b == B_LITERAL || b == B_STATE) begin
            jamo_ini    = SLOT_NONE;
            jamo_med    = SLOT_NONE;
            jamo_fin    = SLOT_NONE;
            jamo_clash  = 1'b0;
            end_armed   = 1'b0;
            token_bytes = 1;
            st          = (b == B_LITERAL) ? ST_LIT_TYPE : ST_ARG;
        end else begin
            close_block(KIND_REJECT);
        end
    endfunction

    // One token byte of a formula; an end op followed by a value start closes it.
    function automatic void take_token(logic [7:0] b);
        if (end_armed) begin
            end_armed = 1'b0;
            if (b == B_PLAIN || b == B_LITERAL || b == B_STATE || b == B_WIDE) begin
                if (jamo_clash)
                    push_key(VT_FORMULA, '0, SLOT_NONE, SLOT_NONE, SLOT_NONE);
                else
                    push_key(VT_FORMULA, '0, jamo_ini, jamo_med, jamo_fin);
                st = ST_VALUE;
                start_value(b);
                return;
            end
        end
        if (token_bytes >= MAX_FORMULA_BYTES) begin
            close_block(KIND_REJECT);
            return;
        end
        token_bytes++;
        if (b == B_LITERAL)
            st = ST_LIT_TYPE;
        else if (b == B_STATE)
            st = ST_ARG;
        else if (b == B_OP_END_A || b == B_OP_END_B)
            end_armed = 1'b1;
    endfunction

    // A second literal for any slot marks the whole formula as ambiguous.
    function automatic void store_literal(logic [7:0] b);
        logic [11:0] v;
        v = {1'b0, b, held_byte[2:0]};
        case (held_byte[7:3])
            PT_INITIAL: if (jamo_ini != SLOT_NONE) jamo_clash = 1'b1; else jamo_ini = v;
            PT_MEDIAL:  if (jamo_med != SLOT_NONE) jamo_clash = 1'b1; else jamo_med = v;
            PT_FINAL:   if (jamo_fin != SLOT_NONE) jamo_clash = 1'b1; else jamo_fin = v;
            default: ;
        endcase
    endfunction

    function automatic void parse_byte(t_in x);
        logic [7:0]  b;
        logic [4:0]  t;
        logic [2:0]  vt;
        b         = x.data_byte;
        beats_now = 0;
        if (closed) begin
            if (x.end_of_stream) clear_parser();
            return;
        end
        case (st)
            ST_HEADER: take_header(b);
            ST_VALUE:  start_value(b);
            ST_PLAIN_TYPE: begin
                t = b[7:3];
                if (t == PT_CHAR || t == PT_INITIAL || t == PT_MEDIAL ||
                    t == PT_FINAL || t == PT_WIDE) begin
                    held_byte = b;
                    st        = ST_PLAIN_INDEX;
                end else begin
                    close_block(KIND_REJECT);
                end
            end
            ST_PLAIN_INDEX: begin
                t  = held_byte[7:3];
                vt = (t == PT_CHAR) ? VT_CHAR : (t == PT_WIDE) ? VT_UNKNOWN : 3'(t - 5'd1);
                push_key(vt, {b, held_byte[2:0]}, SLOT_NONE, SLOT_NONE, SLOT_NONE);
                if (t == PT_WIDE) begin
                    discard_left = 2'd1;
                    st           = ST_DISCARD;
                end else begin
                    st = ST_VALUE;
                end
            end
            ST_DISCARD: begin
                discard_left = discard_left - 2'd1;
                if (discard_left == 2'd0) st = ST_VALUE;
            end
            ST_TOKEN: take_token(b);
            ST_LIT_TYPE: begin
                token_bytes++;
                held_byte = b;
                st        = ST_LIT_INDEX;
            end
            ST_LIT_INDEX: begin
                token_bytes++;
                store_literal(b);
                st = ST_TOKEN;
            end
            ST_ARG: begin
                token_bytes++;
                st = ST_TOKEN;
            end
            default: close_block(KIND_REJECT);
        endcase
        if (x.end_of_stream) begin
            if (!closed) close_block(KIND_REJECT);
            clear_parser();
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    // One-byte op; after an end op it must not look like the start of a value.
    function automatic logic [7:0] free_op(bit after_end);
        logic [7:0] b;
        b = 8'($urandom);
        while (b == B_LITERAL || b == B_STATE || b == B_OP_END_A || b == B_OP_END_B ||
               (after_end && (b == B_PLAIN || b == B_WIDE)))
            b = 8'($urandom);
        return b;
    endfunction

    // First literal byte: mostly a jamo type, sometimes anything.
    function automatic logic [7:0] jamo_byte();
        if ($urandom_range(3) == 0) return 8'($urandom);
        return {5'(PT_INITIAL + $urandom_range(2)), 3'($urandom)};
    endfunction

    function automatic void add_header(int keys);
        int lo;
        lo = $urandom_range(int'(KEY_LOW), int'(KEY_HIGH) - keys + 1);
        block_bytes.push_back(8'($urandom_range(1)));
        block_bytes.push_back(8'(lo));
        block_bytes.push_back(8'(lo + keys - 1));
        block_bytes.push_back(8'd0);
        block_bytes.push_back(8'd0);
        block_bytes.push_back(8'd1);
        block_bytes.push_back(8'($urandom));
        block_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_formula(int tokens);
        for (int i = 0; i < tokens; i++) begin
            case ((i == 0) ? $urandom_range(1) : $urandom_range(5))
                0, 2: begin
                    block_bytes.push_back(B_LITERAL);
                    block_bytes.push_back(jamo_byte());
                    block_bytes.push_back(8'($urandom));
                end
                1: begin
                    block_bytes.push_back(B_STATE);
                    block_bytes.push_back(8'($urandom));
                end
                3, 4: block_bytes.push_back(free_op(1'b0));
                default: begin
                    // End op in the middle: the next byte keeps the formula going.
                    block_bytes.push_back($urandom_range(1) ? B_OP_END_A : B_OP_END_B);
                    block_bytes.push_back(free_op(1'b1));
                end
            endcase
        end
        block_bytes.push_back($urandom_range(1) ? B_OP_END_A : B_OP_END_B);
    endfunction

    function automatic void add_value();
        logic [4:0] t;
        case ($urandom_range(2))
            0: begin
                case ($urandom_range(4))
                    0: t = PT_CHAR;
                    1: t = PT_INITIAL;
                    2: t = PT_MEDIAL;
                    3: t = PT_FINAL;
                    default: t = PT_WIDE;
                endcase
                block_bytes.push_back(B_PLAIN);
                block_bytes.push_back({t, 3'($urandom)});
                block_bytes.push_back(8'($urandom));
                if (t == PT_WIDE) block_bytes.push_back(8'($urandom));
            end
            1: begin
                block_bytes.push_back(B_WIDE);
                block_bytes.push_back(8'($urandom));
                block_bytes.push_back(8'($urandom));
            end
            default: add_formula($urandom_range(1, 6));
        endcase
    endfunction

    // Moves the block into the byte queue, with end of stream on its last byte.
    function automatic void commit_block();
        t_in beat;
        foreach (block_bytes[k]) begin
            beat.data_byte     = block_bytes[k];
            beat.end_of_stream = (k == block_bytes.size() - 1);
            pending_bytes.push_back(beat);
        end
        block_bytes.delete();
    endfunction

    function automatic void add_good_block(int keys);
        add_header(keys);
        repeat (keys) add_value();
        block_bytes.push_back(B_PLAIN);
    endfunction

    task automatic build_stimulus();
        int roll, keys, cut, goal;
        // Widest type-10 index, a wide value, then an ok terminator.
        block_bytes = '{8'h01, 8'h20, 8'h21, 8'h00, 8'h00, 8'h01, 8'hff, 8'h00,
                        8'h00, 8'h57, 8'hff, 8'h33, 8'h79, 8'haa, 8'hbb, 8'h00};
        commit_block();
        // Formula closed by a wide value on the last byte: two keys, status lost.
        block_bytes = '{8'h00, 8'h7c, 8'h7e, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                        8'h02, 8'h80, 8'h59, 8'h79};
        commit_block();
        // Bad flag byte at once.
        block_bytes = '{8'h02};
        commit_block();

        // Widest key range, and a formula that runs past its length limit.
        add_good_block(95);
        commit_block();
        add_header(2);
        add_formula(180);
        add_value();
        block_bytes.push_back(B_PLAIN);
        commit_block();

        goal = ITEMS;
        while (pending_bytes.size() < goal) begin
            roll = $urandom_range(99);
            if (roll < 94) begin
                keys = ($urandom_range(19) == 0) ? $urandom_range(6, 24) : $urandom_range(2, 5);
                add_good_block(keys);
                if (roll < 70) begin
                    // Well formed, with bytes after the terminator that are ignored.
                    repeat ($urandom_range(2)) block_bytes.push_back(8'($urandom));
                end else if (roll < 80) begin
                    block_bytes[$urandom_range(block_bytes.size() - 1)] = 8'($urandom);
                end else if (roll < 88) begin
                    cut = $urandom_range(1, block_bytes.size() - 1);
                    while (block_bytes.size() > cut) void'(block_bytes.pop_back());
                end else begin
                    block_bytes[block_bytes.size() - 1] = 8'($urandom_range(1, 255));
                end
            end else begin
                repeat ($urandom_range(1, 6)) block_bytes.push_back(8'($urandom));
            end
            commit_block();
        end
    endtask

    // ---------------------------------------------------------------- driver and monitor

    function automatic bit idle_roll();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(99) < 11;
    endfunction

    // The sender stops once until every expected beat has come back.
    function automatic bit sender_waits();
        if (bytes_sent == PAUSE_AT && expected_results.size() != 0) return 1'b1;
        return idle_roll();
    endfunction

    // Byte driver: predicts each accepted beat and offers the next one.
    always @(posedge clk) begin : byte_driver
        logic took;
        took = byte_valid && !byte_stall;
        if (!rst_n) begin
            byte_valid <= 1'b0;
        end else begin
            if (took) begin
                parse_byte(pending_bytes.pop_front());
                bytes_sent++;
            end
            if (!byte_valid || took) begin
                if (pending_bytes.size() != 0 && !sender_waits()) begin
                    byte_valid <= 1'b1;
                    byte_beat  <= pending_bytes[0];
                end else begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result(t_result want, t_result got);
        compare_field("kind",            int'(want.kind),            int'(got.kind));
        compare_field("key_char",        int'(want.key_char),        int'(got.key_char));
        compare_field("value_type",      int'(want.value_type),      int'(got.value_type));
        compare_field("code_index",      int'(want.code_index),      int'(got.code_index));
        compare_field("formula_initial", int'(want.formula_initial), int'(got.formula_initial));
        compare_field("formula_medial",  int'(want.formula_medial),  int'(got.formula_medial));
        compare_field("formula_final",   int'(want.formula_final),   int'(got.formula_final));
        compare_field("key_total",       int'(want.key_total),       int'(got.key_total));
        compare_field("last",            int'(want.last),            int'(got.last));
    endfunction

    // Length of the long receiver hold-off, counted down once per cycle.
    always @(posedge clk) begin : holdoff_count
        if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end else if (cycle_count == HOLD_AT) begin
            holdoff_left <= HOLD_LEN;
        end
    end

    // Result monitor: checks each accepted beat and drives the stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
        end else begin
            if (result_valid && !result_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    check_result(expected_results.pop_front(), result_beat);
                end
            end
            // One long hold-off lets the result queue fill and stall the input.
            if (holdoff_left != 0 || cycle_count == HOLD_AT) begin
                result_stall <= 1'b1;
            end else begin
                result_stall <= idle_roll();
            end
        end
    end

    // ---------------------------------------------------------------- run control

    initial begin
        clear_parser();
        build_stimulus();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

endmodule
